>>> rtl/assert_macros.svh
// Assertion macros used by the RTL back end (lzc_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LZC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lzc check failed");
`define LZC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lzc check failed");
`else
`define LZC_ASSERT(lbl, prop)
`define LZC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> rtl/lzc_pkg.sv
// Types and constants of the LZ77 container decompressor.
package lzc_pkg;
   typedef enum logic [1:0] {OP_NONE, OP_LIT, OP_MATCH} op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic [15:0] offset;
      logic [7:0]  len;
      logic        fe;
      logic [2:0]  status;
   } cmd_type;

   localparam logic [7:0] MAGIC0 = 8'h52;
   localparam logic [7:0] MAGIC1 = 8'h58;
   localparam logic [7:0] MAGIC2 = 8'h43;
   localparam logic [7:0] MODE_STORED_CODE = 8'h00;
   localparam logic [7:0] MODE_COMP_CODE = 8'h01;
   localparam logic [7:0] TOK_MATCH = 8'h00;
   localparam logic [7:0] TOK_ZERO = 8'h01;
   localparam logic [3:0] HEADER_LEN = 4'd8;
   localparam int MAX_RESULTS = 32;

   localparam logic [1:0] FM_NONE = 2'd0;
   localparam logic [1:0] FM_STORED = 2'd1;
   localparam logic [1:0] FM_COMP = 2'd2;
   localparam logic [1:0] FM_DISCARD = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_MAGIC = 3'd2;
   localparam logic [2:0] ST_MODE = 3'd3;
   localparam logic [2:0] ST_SIZE = 3'd4;
   localparam logic [2:0] ST_OFFSET = 3'd5;
endpackage

>>> rtl/lz77_container_decompressor.sv
// A literal passes the command queue, then S_EMIT, then the output register.
// Header and dropped-token bytes pop in S_IDLE, with S_EMIT only at frame end; a match of
// length L reads then writes history per byte (S_RD, S_WR), with an S_EMIT per result.
// A four-entry command queue lets the front accept up to four items while the back is busy.
// Reset (synchronous, active high) clears frame state, queue and output; history is not cleared.
module lz77_container_decompressor import lzc_pkg::*; #(
   parameter int HISTORY_DEPTH = 65536,
   parameter int OUT_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_data[63:0], out_count[67:64], zero pad
   output logic        rsp_tlast,   // run_last
   output logic [3:0]  rsp_tuser    // frame_done[0], status[3:1]
);
   cmd_type     f_cmd, q_cmd;
   logic        q_full, q_valid, q_pop, accept, done;
   logic [63:0] odata;
   logic [3:0]  ocount;
   logic [2:0]  ostatus;

   assign req_tready = !q_full;
   assign accept = req_tvalid && !q_full;

   lzc_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
      .clock, .reset, .accept, .in_byte(req_tdata), .frame_end(req_tlast), .cmd(f_cmd)
   );

   lzc_queue u_queue (
      .clock, .reset, .push(accept), .push_cmd(f_cmd), .full(q_full),
      .pop(q_pop), .not_empty(q_valid), .pop_cmd(q_cmd)
   );

   lzc_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .OUT_BYTES(OUT_BYTES)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_data(odata),
      .rsp_count(ocount), .rsp_last(rsp_tlast), .rsp_done(done), .rsp_status(ostatus)
   );

   assign rsp_tdata = {4'd0, ocount, odata};
   assign rsp_tuser = {ostatus, done};
endmodule

>>> rtl/lzc_front.sv
// Front end: header check, token decode, one command per accepted byte.
module lzc_front import lzc_pkg::*; #(
   parameter int HISTORY_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  in_byte,
   input  logic        frame_end,
   output cmd_type     cmd
);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [17:0] DEPTH18 = 18'(HISTORY_DEPTH);

   logic [3:0]       hidx_ff, hidx_in;
   logic [1:0]       mode_ff, mode_in;
   logic [31:0]      size_ff, size_in;
   logic [1:0]       phase_ff, phase_in;
   logic [15:0]      off_ff, off_in;
   logic [31:0]      prod_ff, prod_in;
   logic [2:0]       stat_ff, stat_in;
   logic [CNT_W-1:0] hcnt_ff, hcnt_in;
   logic [7:0]       add;
   logic [17:0]      hsum;
   logic             in_header, off_ok;

   assign in_header = hidx_ff < HEADER_LEN;
   assign off_ok = (off_ff != 16'd0) && ({2'b0, off_ff} <= DEPTH18)
                   && ({2'b0, off_ff} <= 18'(hcnt_ff));

   always_comb begin
      hidx_in = hidx_ff; mode_in = mode_ff; size_in = size_ff;
      phase_in = phase_ff; off_in = off_ff; stat_in = stat_ff;
      add = 8'd0;
      cmd.op = OP_NONE; cmd.data = in_byte; cmd.offset = off_ff;
      cmd.len = in_byte; cmd.fe = frame_end; cmd.status = ST_OK;
      if (in_header) begin
         case (hidx_ff[2:0])
            3'd0: if (in_byte != MAGIC0 && stat_in == ST_OK) stat_in = ST_MAGIC;
            3'd1: if (in_byte != MAGIC1 && stat_in == ST_OK) stat_in = ST_MAGIC;
            3'd2: if (in_byte != MAGIC2 && stat_in == ST_OK) stat_in = ST_MAGIC;
            3'd3: begin
               if (in_byte == MODE_STORED_CODE) mode_in = FM_STORED;
               else if (in_byte == MODE_COMP_CODE) mode_in = FM_COMP;
               else begin
                  mode_in = FM_DISCARD;
                  if (stat_in == ST_OK) stat_in = ST_MODE;
               end
            end
            3'd4: size_in[7:0] = in_byte;
            3'd5: size_in[15:8] = in_byte;
            3'd6: size_in[23:16] = in_byte;
            default: size_in[31:24] = in_byte;
         endcase
         if (hidx_ff[2:0] == 3'd7 && stat_in != ST_OK) mode_in = FM_DISCARD;
         hidx_in = hidx_ff + 4'd1;
      end else if (mode_ff == FM_STORED) begin
         cmd.op = OP_LIT;
         add = 8'd1;
      end else if (mode_ff == FM_COMP) begin
         case (phase_ff)
            2'd0: begin
               if (in_byte == TOK_MATCH) phase_in = 2'd1;
               else begin
                  cmd.op = OP_LIT;
                  add = 8'd1;
                  if (in_byte == TOK_ZERO) cmd.data = 8'h00;
               end
            end
            2'd1: begin
               off_in = {8'h00, in_byte};
               phase_in = 2'd2;
            end
            2'd2: begin
               off_in = {in_byte, off_ff[7:0]};
               phase_in = 2'd3;
            end
            default: begin
               if (!off_ok) begin
                  if (stat_in == ST_OK) stat_in = ST_OFFSET;
               end else if (in_byte != 8'd0) begin
                  cmd.op = OP_MATCH;
                  add = in_byte;
               end
               phase_in = 2'd0;
            end
         endcase
      end
      prod_in = prod_ff + {24'd0, add};
      hsum = 18'(hcnt_ff) + {10'd0, add};
      hcnt_in = (hsum >= DEPTH18) ? CNT_W'(HISTORY_DEPTH) : hsum[CNT_W-1:0];
      if (frame_end) begin
         if (in_header) stat_in = ST_SHORT;
         else if (mode_ff == FM_STORED && prod_in != size_ff && stat_in == ST_OK)
            stat_in = ST_SIZE;
         cmd.status = stat_in;
         hidx_in = 4'd0; mode_in = FM_NONE; size_in = 32'd0; phase_in = 2'd0;
         off_in = 16'd0; prod_in = 32'd0; stat_in = ST_OK; hcnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hidx_ff <= 4'd0; mode_ff <= FM_NONE; size_ff <= 32'd0; phase_ff <= 2'd0;
         off_ff <= 16'd0; prod_ff <= 32'd0; stat_ff <= ST_OK; hcnt_ff <= '0;
      end else if (accept) begin
         hidx_ff <= hidx_in; mode_ff <= mode_in; size_ff <= size_in;
         phase_ff <= phase_in; off_ff <= off_in; prod_ff <= prod_in;
         stat_ff <= stat_in; hcnt_ff <= hcnt_in;
      end
   end
endmodule

>>> rtl/lzc_queue.sv
// Four-entry command queue between front and back.
module lzc_queue import lzc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_cmd
);
   cmd_type    slots_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   assign full = cnt_ff == 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign pop_cmd = slots_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 2'd0; rd_ff <= 2'd0; cnt_ff <= 3'd0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b0, push} - {2'b0, pop};
      end
   end
endmodule

>>> rtl/lzc_back.sv
// Back end: history memory, match copy and result packing.
module lzc_back import lzc_pkg::*; #(
   parameter int HISTORY_DEPTH = 65536,
   parameter int OUT_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_data,
   output logic [3:0]  rsp_count,
   output logic        rsp_last,
   output logic        rsp_done,
   output logic [2:0]  rsp_status
);
`include "assert_macros.svh"
   localparam int ADDR_W = $clog2(HISTORY_DEPTH);
   localparam logic [17:0] DEPTH18 = 18'(HISTORY_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_RD, S_WR, S_EMIT} state_type;

   logic [7:0]        hist [HISTORY_DEPTH];
   state_type         state_ff;
   logic [ADDR_W-1:0] wp_ff, wp_next, rd_addr;
   logic [15:0]       off_ff;
   logic [7:0]        rem_ff, rdata_ff, wdata;
   logic [5:0]        ridx_ff;
   logic [63:0]       pack_ff, pack_merged;
   logic [3:0]        packn_ff;
   logic              fe_ff, lastf_ff, we, out_free, chunk_full;
   logic [2:0]        stat_ff;
   logic [17:0]       rd_sum, rd_wrap;
   logic              rsp_valid_ff, rsp_last_ff, rsp_done_ff;
   logic [63:0]       rsp_data_ff;
   logic [3:0]        rsp_count_ff;
   logic [2:0]        rsp_status_ff;

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign we = (q_pop && q_cmd.op == OP_LIT) || (state_ff == S_WR);
   assign wdata = (state_ff == S_WR) ? rdata_ff : q_cmd.data;
   assign wp_next = (wp_ff == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rd_sum = 18'(wp_ff) + DEPTH18 - {2'b0, off_ff};
   assign rd_wrap = (rd_sum >= DEPTH18) ? rd_sum - DEPTH18 : rd_sum;
   assign rd_addr = rd_wrap[ADDR_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign chunk_full = (packn_ff + 4'd1 >= 4'(OUT_BYTES)) || (rem_ff == 8'd1);

   always_comb begin
      pack_merged = pack_ff;
      pack_merged[packn_ff[2:0]*8 +: 8] = rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (we) hist[wp_ff] <= wdata;
      if (state_ff == S_RD) rdata_ff <= hist[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; wp_ff <= '0;
         pack_ff <= 64'd0; packn_ff <= 4'd0;
      end else begin
         // S_EMIT reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_EMIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (q_pop) begin
               fe_ff <= q_cmd.fe;
               stat_ff <= q_cmd.status;
               off_ff <= q_cmd.offset;
               ridx_ff <= 6'd0;
               lastf_ff <= 1'b1;
               case (q_cmd.op)
                  OP_LIT: begin
                     pack_ff <= {56'd0, q_cmd.data};
                     packn_ff <= 4'd1;
                     rem_ff <= 8'd0;
                     wp_ff <= wp_next;
                     state_ff <= S_EMIT;
                  end
                  OP_MATCH: begin
                     pack_ff <= 64'd0;
                     packn_ff <= 4'd0;
                     rem_ff <= q_cmd.len;
                     state_ff <= S_RD;
                  end
                  default: begin
                     pack_ff <= 64'd0;
                     packn_ff <= 4'd0;
                     rem_ff <= 8'd0;
                     if (q_cmd.fe) state_ff <= S_EMIT;
                  end
               endcase
            end
            S_RD: state_ff <= S_WR;
            S_WR: begin
               rem_ff <= rem_ff - 8'd1;
               wp_ff <= (!chunk_full || ridx_ff < 6'(MAX_RESULTS) || rem_ff != 8'd1 || !fe_ff)
                        ? wp_next : '0;
               if (!chunk_full) begin
                  pack_ff <= pack_merged;
                  packn_ff <= packn_ff + 4'd1;
                  state_ff <= S_RD;
               end else if (ridx_ff < 6'(MAX_RESULTS)) begin
                  pack_ff <= pack_merged;
                  packn_ff <= packn_ff + 4'd1;
                  lastf_ff <= (rem_ff == 8'd1) || (ridx_ff == 6'(MAX_RESULTS - 1));
                  state_ff <= S_EMIT;
               end else begin
                  // past the result cap: bytes still go to history only
                  pack_ff <= 64'd0;
                  packn_ff <= 4'd0;
                  if (rem_ff == 8'd1) state_ff <= S_IDLE;
                  else state_ff <= S_RD;
               end
            end
            S_EMIT: if (out_free) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff <= pack_ff;
               rsp_count_ff <= packn_ff;
               rsp_last_ff <= lastf_ff;
               rsp_done_ff <= lastf_ff && fe_ff;
               rsp_status_ff <= (lastf_ff && fe_ff) ? stat_ff : ST_OK;
               pack_ff <= 64'd0;
               packn_ff <= 4'd0;
               ridx_ff <= ridx_ff + 6'd1;
               if (rem_ff == 8'd0) begin
                  state_ff <= S_IDLE;
                  if (fe_ff) wp_ff <= '0;
               end else state_ff <= S_RD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_done = rsp_done_ff;
   assign rsp_status = rsp_status_ff;

   `LZC_ASSERT_IMP(a_done_is_last, rsp_valid_ff && rsp_done_ff, rsp_last_ff)
   `LZC_ASSERT_IMP(a_status_on_close, rsp_valid_ff && !rsp_done_ff, rsp_status_ff == ST_OK)
   `LZC_ASSERT_IMP(a_count_range, rsp_valid_ff,
      rsp_count_ff <= 4'(OUT_BYTES) && (rsp_count_ff != 4'd0 || rsp_done_ff))
endmodule
